// ===== design/upst_pkg.sv =====
// Shared types and constants for the UDP port socket table.
package upst_pkg;

    localparam int DEFAULT_SLOTS = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int PORT_W        = 16;
    localparam int HANDLE_W      = 4;
    localparam int CNT_W         = 4;
    localparam int TDATA_W       = ((HANDLE_W + PORT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_BIND    = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_DELIVER = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] slot_handle;
        logic [PORT_W-1:0]   slot_port;
        logic                matched;
        logic                last;
    } result_t;

endpackage

// ===== design/udp_port_socket_table.sv =====
// Top level of the UDP port socket table: slot memory, scan sequencer and result port.
//
//   channel   direction  tdata (low bit up)               tuser       tlast
//   s_ (op)   in         port_number[15:0], handle[19:16]  opcode[1:0] -
//   m_ (res)  out        slot_handle[3:0], slot_port[19:4] matched[0]  last
//
// Scan: one slot is read per cycle from the single-read-port slot memory unless a
// result is held back by the output register; a deliver reads every slot up to the
// MAX_RESULTS-th match, a bind up to the first free one, close or query the one addressed.
// Items are handled one at a time; s_tready is high only while the sequencer idles.
// Reset clears the per-slot valid bits at once, so every slot reads free with no
// clearing pass. A stalled master holds the sequencer only when it has a result to
// place and the output register is still occupied.
module udp_port_socket_table
    import upst_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // port_number[15:0], handle[19:16], zero pad
    input  logic [1:0]         s_tuser,   // opcode[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // slot_handle[3:0], slot_port[19:4], zero pad
    output logic [0:0]         m_tuser,   // matched[0]
    output logic               m_tlast
);

    localparam int            IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [7:0]    SLOTS_W  = 8'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // sequencer state
    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic                hok_reg, hok_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0] pend_handle_reg, pend_handle_next;

    // slot memory and its read/write ports
    logic [PORT_W-1:0]   bound_ports_mem [SLOTS];
    logic [SLOTS-1:0]    slot_valid_reg;
    logic [PORT_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                mem_we;
    logic [IW-1:0]       wr_addr;
    logic [PORT_W-1:0]   wr_data;
    logic [PORT_W-1:0]   rd_word;

    // input decode
    logic                in_fire;
    opcode_t             s_op;
    logic [PORT_W-1:0]   s_port;
    logic [HANDLE_W-1:0] s_handle;
    logic [7:0]          h_ext;
    logic [7:0]          h_m1;
    logic                h_ok;
    logic [IW-1:0]       start_idx;

    // scan evaluation
    logic [7:0]          hnd_ext;
    logic [HANDLE_W-1:0] cur_handle;
    logic                last_slot;
    logic                cap_hit;
    logic                slot_free;
    logic                port_hit;

    // result path
    logic                out_load;
    logic                out_free;
    result_t             out_data;
    result_t             fail_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign s_op      = opcode_t'(s_tuser);
    assign s_port    = s_tdata[PORT_W-1:0];
    assign s_handle  = s_tdata[PORT_W+HANDLE_W-1:PORT_W];
    assign h_ext     = {{(8 - HANDLE_W){1'b0}}, s_handle};
    assign h_m1      = h_ext - 8'd1;
    assign h_ok      = (h_ext != 8'd0) && (h_ext <= SLOTS_W);
    assign start_idx = (s_op == OP_CLOSE || s_op == OP_QUERY) ? h_m1[IW-1:0] : '0;

    // a slot never written since reset reads as free
    assign rd_word    = rd_valid_reg ? rd_data_reg : '0;
    assign hnd_ext    = 8'(idx_reg) + 8'd1;
    assign cur_handle = hnd_ext[HANDLE_W-1:0];
    assign last_slot  = (idx_reg == LAST_IDX);
    assign cap_hit    = (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign slot_free  = (rd_word == '0);
    assign port_hit   = (port_reg != '0) && (rd_word == port_reg);

    always_comb begin
        fail_res             = '0;
        fail_res.last        = 1'b1;
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        port_next        = port_reg;
        hok_next         = hok_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg + IW'(1);
        mem_we           = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = port_reg;
        out_load         = 1'b0;
        out_data         = fail_res;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    // latch the request and read the first slot of interest
                    op_next         = s_op;
                    port_next       = s_port;
                    hok_next        = h_ok;
                    idx_next        = start_idx;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    rd_en           = 1'b1;
                    rd_addr         = start_idx;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                unique case (op_reg)
                    OP_BIND: begin
                        if (port_reg != '0 && slot_free) begin
                            if (out_free) begin
                                out_load             = 1'b1;
                                out_data.slot_handle = cur_handle;
                                out_data.slot_port   = port_reg;
                                out_data.matched     = 1'b1;
                                mem_we               = 1'b1;
                                state_next           = ST_IDLE;
                            end
                        end else if (port_reg == '0 || last_slot) begin
                            // zero port or table full: reject
                            if (out_free) begin
                                out_load   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            rd_en    = 1'b1;
                            idx_next = idx_reg + IW'(1);
                        end
                    end

                    OP_CLOSE, OP_QUERY: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (hok_reg) begin
                                out_data.slot_handle = cur_handle;
                                out_data.slot_port   = rd_word;
                                out_data.matched     = 1'b1;
                                mem_we               = (op_reg == OP_CLOSE);
                                wr_data              = '0;
                            end
                        end
                    end

                    OP_DELIVER: begin
                        if (port_hit && pend_valid_reg && !out_free) begin
                            // hold: earlier match cannot leave yet
                            state_next = ST_SCAN;
                        end else begin
                            if (port_hit) begin
                                if (pend_valid_reg) begin
                                    out_load             = 1'b1;
                                    out_data.slot_handle = pend_handle_reg;
                                    out_data.slot_port   = port_reg;
                                    out_data.matched     = 1'b1;
                                    out_data.last        = 1'b0;
                                end
                                pend_valid_next  = 1'b1;
                                pend_handle_next = cur_handle;
                                cnt_next         = cnt_reg + CNT_W'(1);
                            end
                            if (last_slot || (port_hit && cap_hit)) begin
                                state_next = ST_FLUSH;
                            end else begin
                                rd_en    = 1'b1;
                                idx_next = idx_reg + IW'(1);
                            end
                        end
                    end

                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_FLUSH: begin
                // emit the held match as final, or a single no-match result
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_valid_reg) begin
                        out_data.slot_handle = pend_handle_reg;
                        out_data.slot_port   = port_reg;
                        out_data.matched     = 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        port_reg        <= port_next;
        hok_reg         <= hok_next;
        idx_reg         <= idx_next;
        pend_handle_reg <= pend_handle_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bound_ports_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= bound_ports_mem[rd_addr];
            rd_valid_reg <= slot_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (mem_we) begin
            slot_valid_reg[wr_addr] <= 1'b1;
        end
    end

    upst_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == ST_SCAN)
        else $error("accepted transfer did not start a scan");

    a_match_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("match count beyond result limit");

    a_flush_deliver_only: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> op_reg == OP_DELIVER)
        else $error("flush entered for an operation other than deliver");

    a_write_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_SCAN && out_load)
        else $error("slot write without its result transfer");

    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded into an occupied output register");
`endif

endmodule

// ===== design/upst_out_stage.sv =====
// Output holding register that decouples result production from the master side.
module upst_out_stage
    import upst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  result_t            load_data,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // slot_handle[3:0], slot_port[19:4], zero pad
    output logic [0:0]         m_tuser,   // matched[0]
    output logic               m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // a waiting result that is taken this cycle frees the register
    assign free = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W - HANDLE_W - PORT_W){1'b0}},
                       data_reg.slot_port, data_reg.slot_handle};
    assign m_tuser  = data_reg.matched;
    assign m_tlast  = data_reg.last;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the UDP port socket table: bind, close, query and deliver traffic.
`timescale 1ns / 1ps

module tb
    import upst_pkg::*;
();

    localparam int CLK_HALF     = 2;
    localparam int RANDOM_ITEMS = 210;
    // Allow about four times the slowest legal run (eight results per item, each behind a
    // long sink stall, plus long source gaps).
    localparam int RUN_LIMIT_NS = 2_000_000;

    // Ports that random traffic binds and delivers to most of the time, so that
    // deliver finds one or more bound slots rather than only no-match results.
    localparam logic [PORT_W-1:0] HOT_PORTS [4] = '{16'd53, 16'd80, 16'hFFFF, 16'h8001};

    // Mirror of the slot table plus the queue of results that the table still owes.
    class socket_table_scoreboard;
        logic [PORT_W-1:0] bound [DEFAULT_SLOTS];
        result_t           owed_results [$];
        int                failures;
        int                results_checked;
        int                widest_fanout;
        int                op_count [4];

        function new();
            foreach (bound[i]) bound[i] = '0;
            failures        = 0;
            results_checked = 0;
            widest_fanout   = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Update the mirror for one accepted operation and queue what it must return.
        function void note_input(opcode_t op, logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] hdl);
            result_t r;
            int      hits;
            int      emitted;
            r = '0;
            r.last = 1'b1;
            op_count[op]++;
            case (op)
                OP_BIND: begin
                    if (port != '0) begin
                        for (int i = 0; i < DEFAULT_SLOTS; i++) begin
                            if (!r.matched && bound[i] == '0) begin
                                bound[i]      = port;
                                r.slot_handle = HANDLE_W'(i + 1);
                                r.slot_port   = port;
                                r.matched     = 1'b1;
                            end
                        end
                    end
                    owed_results.push_back(r);
                end
                OP_CLOSE, OP_QUERY: begin
                    if (hdl != '0 && hdl <= DEFAULT_SLOTS) begin
                        r.slot_handle = hdl;
                        r.slot_port   = bound[hdl - 1];
                        r.matched     = 1'b1;
                        if (op == OP_CLOSE) bound[hdl - 1] = '0;
                    end
                    owed_results.push_back(r);
                end
                default: begin
                    hits = 0;
                    if (port != '0) begin
                        foreach (bound[i]) if (bound[i] == port) hits++;
                    end
                    if (hits > MAX_RESULTS) hits = MAX_RESULTS;
                    if (hits > widest_fanout) widest_fanout = hits;
                    if (hits == 0) begin
                        owed_results.push_back(r);
                    end else begin
                        emitted = 0;
                        for (int i = 0; i < DEFAULT_SLOTS && emitted < hits; i++) begin
                            if (bound[i] == port) begin
                                emitted++;
                                r.slot_handle = HANDLE_W'(i + 1);
                                r.slot_port   = port;
                                r.matched     = 1'b1;
                                r.last        = (emitted == hits);
                                owed_results.push_back(r);
                            end
                        end
                    end
                end
            endcase
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: handle %0d port %0h matched %0b last %0b",
                       got.slot_handle, got.slot_port, got.matched, got.last);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            if (got.slot_handle !== want.slot_handle) begin
                $error("slot_handle: expected %0d, got %0d", want.slot_handle, got.slot_handle);
                failures++;
            end
            if (got.slot_port !== want.slot_port) begin
                $error("slot_port: expected %0h, got %0h", want.slot_port, got.slot_port);
                failures++;
            end
            if (got.matched !== want.matched) begin
                $error("matched: expected %0b, got %0b", want.matched, got.matched);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;   // port_number[15:0], handle[19:16], zero pad
    logic [1:0]         s_tuser  = '0;   // opcode[1:0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // slot_handle[3:0], slot_port[19:4], zero pad
    logic [0:0]         m_tuser;         // matched[0]
    logic               m_tlast;

    socket_table_scoreboard table_sb = new();
    bit                     src_calm = 1'b0;

    udp_port_socket_table #(.SLOTS(DEFAULT_SLOTS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Idle length: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return HOT_PORTS[$urandom_range(0, 3)];
        if (roll < 95) return PORT_W'($urandom_range(0, 65535));
        return '0;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 4) != 0) return HANDLE_W'($urandom_range(1, DEFAULT_SLOTS));
        return HANDLE_W'($urandom_range(0, 15));
    endfunction

    // Present one operation and hold it until the table takes the transfer. Valid
    // stays high straight into the next item when no gap is asked for.
    task automatic send_op(opcode_t op, logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] hdl,
                           int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(TDATA_W - HANDLE_W - PORT_W){1'b0}}, hdl, port};
        do @(posedge aclk); while (!s_tready);
        table_sb.note_input(op, port, hdl);
    endtask

    // Hold the source idle until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (table_sb.pending() != 0);
    endtask

    // Free every slot, bind one port everywhere, then deliver to it: the widest fan-out.
    task automatic fill_same_port(logic [PORT_W-1:0] port);
        for (int h = 1; h <= DEFAULT_SLOTS; h++)
            send_op(OP_CLOSE, pick_port(), HANDLE_W'(h), pick_gap(src_calm));
        for (int h = 1; h <= DEFAULT_SLOTS; h++)
            send_op(OP_BIND, port, pick_handle(), pick_gap(src_calm));
        send_op(OP_DELIVER, port, pick_handle(), pick_gap(src_calm));
    endtask

    // Sink pacing: alternate calm stretches (always ready) with stretches of random stalls.
    initial begin : sink_pacing
        int stall_left;
        int phase_left;
        bit stalling;
        stall_left = 0;
        phase_left = 0;
        stalling   = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase_left == 0) begin
                stalling   = ($urandom_range(0, 9) < 7);
                phase_left = $urandom_range(50, 400);
            end
            phase_left--;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (stalling && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
            end
        end
    end

    // Check every result transfer against the mirror.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.slot_handle = m_tdata[HANDLE_W-1:0];
            got.slot_port   = m_tdata[HANDLE_W+PORT_W-1:HANDLE_W];
            got.matched     = m_tuser[0];
            got.last        = m_tlast;
            table_sb.check_result(got);
        end
    end

    initial begin : stimulus
        int                 roll;
        logic [PORT_W-1:0]  port;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bad handles, free slots, port zero, no match, full table, fan-out.
        send_op(OP_QUERY,   16'h1234, 4'd0,  0);
        send_op(OP_CLOSE,   16'hFFFF, 4'd15, 0);
        send_op(OP_QUERY,   16'h0000, 4'd9,  1);
        send_op(OP_QUERY,   16'h0001, 4'd1,  0);
        send_op(OP_CLOSE,   16'h8000, 4'd8,  0);
        send_op(OP_BIND,    16'h0000, 4'd5,  0);
        send_op(OP_DELIVER, 16'h0000, 4'd0,  2);
        send_op(OP_DELIVER, 16'h1234, 4'd10, 0);
        for (int h = 0; h < DEFAULT_SLOTS; h++)
            send_op(OP_BIND, 16'd80, HANDLE_W'(h), 0);
        send_op(OP_BIND,    16'hFFFF, 4'd0,  0);
        send_op(OP_DELIVER, 16'd80,   4'd15, 0);
        send_op(OP_CLOSE,   16'h0000, 4'd3,  0);
        send_op(OP_BIND,    16'hFFFF, 4'd0,  3);
        send_op(OP_QUERY,   16'h0000, 4'd3,  0);
        send_op(OP_DELIVER, 16'hFFFF, 4'd0,  0);
        send_op(OP_CLOSE,   16'h0000, 4'd1,  0);
        send_op(OP_DELIVER, 16'd80,   4'd0,  0);
        send_op(OP_CLOSE,   16'h0000, 4'd8,  0);
        drain_results();

        // Random: mostly table traffic on a few hot ports, with bad handles and odd ports mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
            if (n % 90 == 45) fill_same_port(pick_port());
            if (n == RANDOM_ITEMS / 2) drain_results();
            roll = $urandom_range(0, 99);
            port = pick_port();
            if (roll < 30)
                send_op(OP_BIND, port, HANDLE_W'($urandom_range(0, 15)), pick_gap(src_calm));
            else if (roll < 55)
                send_op(OP_CLOSE, port, pick_handle(), pick_gap(src_calm));
            else if (roll < 65)
                send_op(OP_QUERY, port, pick_handle(), pick_gap(src_calm));
            else
                send_op(OP_DELIVER, port, HANDLE_W'($urandom_range(0, 15)), pick_gap(src_calm));
        end

        // Wind down: wait for the owed results, then watch for strays past a full scan.
        drain_results();
        repeat (8 * DEFAULT_SLOTS) @(posedge aclk);
        if (table_sb.pending() != 0) begin
            $error("%0d results never arrived", table_sb.pending());
            table_sb.failures++;
        end
        $display("covered %0d bind, %0d close, %0d query and %0d deliver transfers",
                 table_sb.op_count[OP_BIND], table_sb.op_count[OP_CLOSE],
                 table_sb.op_count[OP_QUERY], table_sb.op_count[OP_DELIVER]);
        $display("%0d results checked, widest deliver fan-out %0d slots",
                 table_sb.results_checked, table_sb.widest_fanout);
        if (table_sb.failures == 0)
            $display("udp_port_socket_table regression: pass");
        else
            $display("udp_port_socket_table regression: fail");
        $finish;
    end

    // Watchdog: a hung handshake ends the run.
    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("udp_port_socket_table regression: fail");
        $finish;
    end

endmodule

// ===== udp_port_socket_table.f =====
design/upst_pkg.sv
design/upst_out_stage.sv
design/udp_port_socket_table.sv
dv/tb.sv
